/* design/ivm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivm_pkg
// Shared types, sizes and codes of the interval value map.
// ----------------------------------------------------------------------------
package ivm_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 8;

    // table address, stored count (0..ENTRIES), build count (0..ENTRIES+2)
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int N_W   = $clog2(ENTRIES + 3);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_VALUE = '0;

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_val;

    typedef struct packed {
        t_key key;
        t_val value;
    } t_entry;

endpackage

/* design/ivm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivm request and response channels
// Valid/ready channels carrying map requests and their results.
// ----------------------------------------------------------------------------
interface ivm_req_if;
    logic            valid;
    logic            ready;
    logic            operation;
    ivm_pkg::t_key   range_start;
    ivm_pkg::t_key   range_end;
    ivm_pkg::t_val   new_value;
    ivm_pkg::t_key   lookup_key;

    modport source (
        output valid, operation, range_start, range_end, new_value, lookup_key,
        input  ready
    );
    modport sink (
        input  valid, operation, range_start, range_end, new_value, lookup_key,
        output ready
    );
endinterface

interface ivm_rsp_if;
    logic            valid;
    logic            ready;
    ivm_pkg::t_val   read_value;
    logic            status;

    modport source (
        output valid, read_value, status,
        input  ready
    );
    modport sink (
        input  valid, read_value, status,
        output ready
    );
endinterface

/* design/ivm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ivm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ivm_apb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivm_apb_regs
// APB register file holding the default value.
// ----------------------------------------------------------------------------
module ivm_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ivm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ivm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ivm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output ivm_pkg::t_val                   o_default_value
);
    import ivm_pkg::*;

    t_val r_default;
    t_val n_default;
    logic wr_stb;

    assign wr_stb = psel && penable && pwrite;

    always_comb begin
        n_default = r_default;
        prdata    = '0;
        unique case (paddr[APB_ADDR_W-1:2])
            REG_DEFAULT_VALUE: begin
                prdata = {{(APB_DATA_W - VALUE_BITS){1'b0}}, r_default};
                if (wr_stb) begin
                    n_default = pwdata[VALUE_BITS-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
        end else begin
            r_default <= n_default;
        end
    end

    assign pready          = 1'b1;
    assign o_default_value = r_default;

endmodule

/* design/ivm_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivm_engine
// Breakpoint table walker: two ping-pong table banks, merge sequencer and
// result register.
// ----------------------------------------------------------------------------
module ivm_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ivm_pkg::t_val i_default_value,
    ivm_req_if.sink       i_req,
    ivm_rsp_if.source     o_rsp
);
    import ivm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [1:0] PH_BELOW = 2'd0;
    localparam logic [1:0] PH_MID   = 2'd1;
    localparam logic [1:0] PH_TAIL  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [N_W-1:0]   r_n, n_n;
    logic             r_op, n_op;
    logic             r_assign, n_assign;
    t_key             r_start, n_start;
    t_key             r_end, n_end;
    t_val             r_val, n_val;
    t_val             r_before, n_before;
    t_val             r_at_end, n_at_end;
    logic             r_out_valid, n_out_valid;
    t_val             r_out_value, n_out_value;
    logic             r_out_status, n_out_status;

    t_entry rdata0, rdata1, rd_ent, wr_ent;
    logic   wr_req, wr_en, we0, we1;
    logic   in_tbl, full;

    // both banks read at the same index; the active bank is selected
    ivm_ram #(.WIDTH($bits(t_entry)), .DEPTH(ENTRIES)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (r_n[IDX_W-1:0]),
        .i_wdata (wr_ent),
        .i_raddr (n_idx[IDX_W-1:0]),
        .o_rdata (rdata0)
    );

    ivm_ram #(.WIDTH($bits(t_entry)), .DEPTH(ENTRIES)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_n[IDX_W-1:0]),
        .i_wdata (wr_ent),
        .i_raddr (n_idx[IDX_W-1:0]),
        .o_rdata (rdata1)
    );

    assign rd_ent = r_bank ? rdata1 : rdata0;
    assign in_tbl = r_idx < r_count;
    assign full   = r_n > N_W'(ENTRIES);
    // entries past capacity are never stored; the build is dropped anyway
    assign wr_en  = wr_req && (r_n < N_W'(ENTRIES));
    assign we0    = wr_en && r_bank;
    assign we1    = wr_en && !r_bank;

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.status = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_bank       = r_bank;
        n_count      = r_count;
        n_idx        = r_idx;
        n_n          = r_n;
        n_op         = r_op;
        n_assign     = r_assign;
        n_start      = r_start;
        n_end        = r_end;
        n_val        = r_val;
        n_before     = r_before;
        n_at_end     = r_at_end;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        wr_req       = 1'b0;
        wr_ent       = rd_ent;

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_req.valid) begin
                    n_op     = i_req.operation;
                    n_start  = i_req.range_start;
                    n_end    = i_req.range_end;
                    n_val    = i_req.new_value;
                    n_before = i_default_value;
                    n_at_end = i_default_value;
                    n_n      = '0;
                    n_assign = 1'b0;
                    if (i_req.operation == OP_LOOKUP) begin
                        n_end   = i_req.lookup_key;
                        n_phase = PH_MID;
                        n_state = S_WALK;
                    end else if (i_req.range_start < i_req.range_end) begin
                        n_assign = 1'b1;
                        n_phase  = PH_BELOW;
                        n_state  = S_WALK;
                    end else begin
                        // empty range: nothing to change
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                unique case (r_phase)
                    PH_BELOW: begin
                        if (in_tbl && (rd_ent.key < r_start)) begin
                            wr_req   = 1'b1;
                            n_n      = r_n + N_W'(1);
                            n_before = rd_ent.value;
                            n_at_end = rd_ent.value;
                            n_idx    = r_idx + CNT_W'(1);
                        end else begin
                            n_phase = PH_MID;
                            if (r_val != r_before) begin
                                wr_req       = 1'b1;
                                wr_ent.key   = r_start;
                                wr_ent.value = r_val;
                                n_n          = r_n + N_W'(1);
                            end
                        end
                    end
                    PH_MID: begin
                        if (in_tbl && (rd_ent.key <= r_end)) begin
                            n_at_end = rd_ent.value;
                            n_idx    = r_idx + CNT_W'(1);
                        end else if (r_op == OP_LOOKUP) begin
                            n_state = S_DONE;
                        end else begin
                            n_phase = PH_TAIL;
                            // old value resumes at the range end
                            if (r_at_end != r_val) begin
                                wr_req       = 1'b1;
                                wr_ent.key   = r_end;
                                wr_ent.value = r_at_end;
                                n_n          = r_n + N_W'(1);
                            end
                        end
                    end
                    PH_TAIL: begin
                        if (in_tbl) begin
                            wr_req = 1'b1;
                            n_n    = r_n + N_W'(1);
                            n_idx  = r_idx + CNT_W'(1);
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                n_idx = '0;
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = (r_op == OP_LOOKUP) ? r_at_end : '0;
                    n_out_status = (r_assign && full) ? ST_FULL : ST_DONE;
                    if (r_assign && !full) begin
                        n_bank  = !r_bank;
                        n_count = r_n[CNT_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_BELOW;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_assign    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bank      <= n_bank;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_assign    <= n_assign;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_start      <= n_start;
        r_end        <= n_end;
        r_val        <= n_val;
        r_before     <= n_before;
        r_at_end     <= n_at_end;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule

/* design/interval_value_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_value_map
// Piecewise-constant key to value map with range assign and key lookup.
// ----------------------------------------------------------------------------
// The map is a sorted table of up to ENTRIES breakpoints; a key below the
// first breakpoint reads the default value register (APB offset 0). An
// assign request gives [range_start, range_end) the new value and keeps the
// table canonical; an empty range changes nothing, and an assign whose
// result would not fit is dropped with status 1. A lookup returns the value
// at lookup_key. Every request yields exactly one result. The table lives in
// two banks of RAM: a request streams the active bank one entry per cycle
// and an assign writes the merged table into the other bank, which becomes
// active only when the assign succeeds. The bank walk sets the request to
// request spacing: an assign walks all N stored breakpoints, a lookup walks
// the breakpoints at or below the key, and an empty range skips the walk.
// A new request is taken only when the walker is back in idle; one finished
// result can wait in the output register while the next request is taken;
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module interval_value_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ivm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ivm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ivm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    ivm_req_if.sink                         i_req,
    ivm_rsp_if.source                       o_rsp
);
    import ivm_pkg::*;

    t_val default_value;

    // config registers
    ivm_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_default_value (default_value)
    );

    // table walker and result register
    ivm_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_default_value (default_value),
        .i_req           (i_req),
        .o_rsp           (o_rsp)
    );

`ifndef SYNTHESIS
    // a result carries either a lookup value or a full flag, never both
    a_rsp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !((o_rsp.status == ST_FULL) && (o_rsp.read_value != '0)))
        else $error("result carries both a value and a full flag");

    // one request at a time: the walker is busy right after taking one
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while walker busy");

    // a new result is loaded only from the finishing state, never from idle
    a_rsp_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> !$past(i_req.ready))
        else $error("result appeared without a request in flight");
`endif

endmodule
